// ===== rtl/fbfl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg
// Field widths and codes shared by the block allocator and its channels.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int REQ_W    = 2;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OFS_W    = 20;
  localparam int FCNT_W   = 8;

  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = SIZE_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd8;
  localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = 13'd4096;

endpackage : fbfl_pkg
`default_nettype wire

// ===== rtl/fbfl_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_req_if
// Request channel: allocate, free or reinitialise, with the block to free.
// ----------------------------------------------------------------------------
interface fbfl_req_if;
  import fbfl_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output req_type, output block_index, input ready);
  modport sink   (input valid, input req_type, input block_index, output ready);

endinterface : fbfl_req_if
`default_nettype wire

// ===== rtl/fbfl_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_rsp_if
// Response channel: status, granted block, its byte offset and free count.
// ----------------------------------------------------------------------------
interface fbfl_rsp_if;
  import fbfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  logic [OFS_W-1:0]    byte_offset;
  logic [FCNT_W-1:0]   free_count;

  modport source (output valid, output status, output granted_index,
                  output byte_offset, output free_count, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input byte_offset, input free_count, output ready);

endinterface : fbfl_rsp_if
`default_nettype wire

// ===== rtl/fixed_block_free_list_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool held as a LIFO free list of next-links in a link
// memory, with a head register and a running free counter.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                          | beat when
//  --------+-----+-------------------------------------------------+-------------
//  req     | in  | req_type, block_index                           | valid&ready
//  rsp     | out | status, granted_index, byte_offset, free_count  | valid&ready
//  cfg     | in  | cfg_index, cfg_wdata                            | cfg_we
//
//  Allocate, free and no-op are accepted, then committed into the response
//  register, with the registered link memory read between.
//  Reset, a register write and a reinitialise request run an init pass over
//  the link memory, one entry a cycle for the effective block count (256 after
//  reset); req.ready is low meanwhile. A reinitialise response is committed
//  after the pass. A held response stalls the commit, not the request accept.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 8
) (
  input  wire                             clk,
  input  wire                             rst,
  fbfl_req_if.sink                        req,
  fbfl_rsp_if.source                      rsp,
  input  wire                             cfg_we,
  input  wire [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [fbfl_pkg::CFG_W-1:0]       cfg_wdata
);
  import fbfl_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);      // block index width
  localparam int LW = $clog2(MAX_BLOCKS + 1);  // link / count width
  localparam int PW = IW + SIZE_W;             // offset product width
  localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_t;

  state_t              state;
  logic [IW-1:0]       init_ptr;
  logic                init_resp;
  logic [IW-1:0]       head;
  logic [IW-1:0]       free_counter;
  logic [COUNT_W-1:0]  num_blocks;
  logic [SIZE_W-1:0]   blk_bytes;
  logic [REQ_W-1:0]    req_q;
  logic [IDX_W-1:0]    idx_q;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_granted;
  logic [OFS_W-1:0]    out_offset;
  logic [FCNT_W-1:0]   out_fcount;

  logic [LW-1:0]       link_mem [MAX_BLOCKS];
  logic [LW-1:0]       rd_data;
  logic                mem_we;
  logic                mem_re;
  logic [IW-1:0]       mem_waddr;
  logic [LW-1:0]       mem_wdata;

  logic [LW-1:0]       eff_count;
  logic [IW-1:0]       init_last;
  logic [SIZE_W-1:0]   size_sat;
  logic [SIZE_W-1:0]   aligned;
  logic [PW-1:0]       prod;
  logic [OFS_W-1:0]    offset;
  logic                slot_free;
  logic                bad_idx;
  logic                empty;
  logic                commit;

  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    granted_next;
  logic [OFS_W-1:0]    offset_next;
  logic [IW-1:0]       fcount_next;
  logic [IW-1:0]       head_next;

  // effective count saturated to 2..MAX_BLOCKS, size to 1..4096
  always_comb begin
    if (32'(num_blocks) < 32'd2) begin
      eff_count = LW'(2);
    end else if (32'(num_blocks) > 32'(MAX_BLOCKS)) begin
      eff_count = LW'(MAX_BLOCKS);
    end else begin
      eff_count = LW'(num_blocks);
    end
    if (blk_bytes == '0) begin
      size_sat = SIZE_W'(1);
    end else if (blk_bytes > SIZE_LIMIT) begin
      size_sat = SIZE_LIMIT;
    end else begin
      size_sat = blk_bytes;
    end
  end

  assign aligned   = (size_sat + SIZE_W'(7)) & ~SIZE_W'(7);
  assign init_last = IW'(eff_count - LW'(1));
  assign prod      = PW'(head) * PW'(aligned);
  assign offset    = OFS_W'(32'(prod) + 32'(HEADER_BYTES));
  assign slot_free = !out_valid || rsp.ready;
  assign bad_idx   = (32'(idx_q) + 32'd1) >= 32'(eff_count);
  assign empty     = rd_data >= END_MARK;
  assign commit    = (state == S_EXEC) && slot_free;

  assign req.ready = (state == S_IDLE);
  assign mem_re    = req.valid && req.ready && (req.req_type == REQ_ALLOC);
  assign mem_we    = (state == S_INIT) ||
                     ((state == S_EXEC) && slot_free && (req_q == REQ_FREE) && !bad_idx);
  assign mem_waddr = (state == S_INIT) ? init_ptr : IW'(idx_q);

  always_comb begin
    if (state == S_INIT) begin
      mem_wdata = (init_ptr == init_last) ? END_MARK : LW'(init_ptr) + LW'(1);
    end else begin
      mem_wdata = LW'(head);
    end
  end

  // response and list update for the request held in req_q / idx_q
  always_comb begin
    status_next  = ST_OK;
    granted_next = '0;
    offset_next  = '0;
    fcount_next  = free_counter;
    head_next    = head;
    case (req_q)
      REQ_ALLOC: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          granted_next = IDX_W'(head);
          offset_next  = offset;
          head_next    = IW'(rd_data);
          if (free_counter != '0) begin
            fcount_next = free_counter - IW'(1);
          end
        end
      end
      REQ_FREE: begin
        if (bad_idx) begin
          status_next = ST_BAD_IDX;
        end else begin
          head_next = IW'(idx_q);
          // double free is not caught; the count saturates
          if (free_counter != init_last) begin
            fcount_next = free_counter + IW'(1);
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // link memory: one write port, one registered read port at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_ptr     <= '0;
      init_resp    <= 1'b0;
      head         <= '0;
      free_counter <= '0;
      num_blocks   <= COUNT_RESET;
      blk_bytes    <= SIZE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (commit && !cfg_we) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_BLOCKS: num_blocks <= cfg_wdata[COUNT_W-1:0];
          CFG_BLK_BYTES:  blk_bytes  <= cfg_wdata;
          default:        blk_bytes  <= cfg_wdata;
        endcase
        state     <= S_INIT;
        init_ptr  <= '0;
        init_resp <= 1'b0;
      end else begin
        unique case (state)
          S_INIT: begin
            if (init_ptr == init_last) begin
              head         <= '0;
              free_counter <= init_last;
              state        <= init_resp ? S_EXEC : S_IDLE;
            end else begin
              init_ptr <= init_ptr + IW'(1);
            end
          end
          S_IDLE: begin
            if (req.valid) begin
              req_q <= req.req_type;
              idx_q <= req.block_index;
              if (req.req_type == REQ_INIT) begin
                state     <= S_INIT;
                init_ptr  <= '0;
                init_resp <= 1'b1;
              end else begin
                state <= S_EXEC;
              end
            end
          end
          S_EXEC: begin
            if (slot_free) begin
              out_status   <= status_next;
              out_granted  <= granted_next;
              out_offset   <= offset_next;
              out_fcount   <= FCNT_W'(fcount_next);
              free_counter <= fcount_next;
              head         <= head_next;
              init_resp    <= 1'b0;
              state        <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_index = out_granted;
  assign rsp.byte_offset   = out_offset;
  assign rsp.free_count    = out_fcount;

  // free counter never exceeds the allocatable blocks outside the init pass
  a_fcount_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (32'(free_counter) < 32'(eff_count)))
    else $error("free counter above pool size");

  // head always points into the pool, sentinel included
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (32'(head) < 32'(eff_count)))
    else $error("head outside pool");

  // one request at a time: an accepted beat drops ready next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !cfg_we) |=> !req.ready)
    else $error("request accepted while busy");

endmodule : fixed_block_free_list_allocator
`default_nettype wire
